// ----- sv/efsa_pkg.sv -----
package efsa_pkg;

	// Sizing of the window store and of the time arithmetic.
	localparam int MAX_WINDOWS = 128;
	localparam int TIME_WIDTH  = 32;
	localparam int WIN_IDX_W   = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

	// Arrival in seconds fits 17 bits even for raw out-of-range fields.
	localparam int ARR_W   = 17;
	// Capped service time in seconds: 1023 * 60 fits 16 bits.
	localparam int SERVE_W = 16;

	// Configuration register indexes.
	localparam logic [2:0] CFG_NUM_WINDOWS = 3'd0;
	localparam logic [2:0] CFG_OPEN        = 3'd1;
	localparam logic [2:0] CFG_CLOSE       = 3'd2;
	localparam logic [2:0] CFG_MAX_SERVICE = 3'd3;

	// Register values after reset.
	localparam logic [7:0]  RST_NUM_WINDOWS = 8'd1;
	localparam logic [16:0] RST_OPEN        = 17'd28800;
	localparam logic [16:0] RST_CLOSE       = 17'd61200;
	localparam logic [9:0]  RST_MAX_SERVICE = 10'd60;

	typedef struct packed {
		logic [7:0]  num_windows;
		logic [16:0] open_seconds;
		logic [16:0] close_seconds;
		logic [9:0]  max_service_minutes;
	} cfg_t;

	// One classified customer as it travels from the front to the back.
	typedef struct packed {
		logic               rejected;
		logic [ARR_W-1:0]   arrive;
		logic [SERVE_W-1:0] serve;
	} item_t;

endpackage

// ----- sv/efsa_front.sv -----
module efsa_front import efsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  arrive_hour,
	input  logic [5:0]  arrive_minute,
	input  logic [5:0]  arrive_second,
	input  logic [9:0]  service_minutes,
	input  logic        q_full,
	output logic        q_push,
	output item_t       q_item
);

	logic             valid_s1;
	item_t            item_s1;
	logic [ARR_W-1:0] arrive;
	logic [9:0]       capped;
	logic             in_xfer;

	// Arrival in seconds and service cap.
	always_comb begin
		arrive = ARR_W'(arrive_hour) * ARR_W'(3600) + ARR_W'(arrive_minute) * ARR_W'(60)
			+ ARR_W'(arrive_second);
		capped = (service_minutes > cfg.max_service_minutes) ? cfg.max_service_minutes
			: service_minutes;
	end

	assign q_push   = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;
	assign in_xfer  = in_valid && !in_stall;
	assign q_item   = item_s1;

	// Stage register holding one classified item until the queue takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.rejected <= arrive > cfg.close_seconds;
			item_s1.arrive   <= arrive;
			item_s1.serve    <= SERVE_W'(capped) * SERVE_W'(60);
		end
	end

endmodule

// ----- sv/efsa_queue.sv -----
module efsa_queue import efsa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  empty
);

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign pop_item = entry_q[rd_ptr_q];

	// Pointers and fill count of the two-entry queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- sv/efsa_back.sv -----
module efsa_back import efsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        reload,
	input  item_t       q_item,
	input  logic        q_empty,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [6:0]  window_index,
	output logic [31:0] wait_seconds,
	output logic [31:0] total_wait_seconds,
	output logic [15:0] accepted_count
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_FINISH = 4'b0100,
		S_WRITE  = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [TIME_WIDTH-1:0]  mem [MAX_WINDOWS];
	logic                   vld_q [MAX_WINDOWS];
	logic [TIME_WIDTH-1:0]  rd_data_q;
	logic                   rd_vld_q;
	logic [WIN_IDX_W-1:0]   rd_addr;
	logic [WIN_IDX_W-1:0]   rd_idx_q;
	logic [WIN_IDX_W-1:0]   last_idx;
	logic [WIN_IDX_W-1:0]   best_q;
	logic [TIME_WIDTH-1:0]  best_val_q;
	logic [TIME_WIDTH-1:0]  entry;
	logic                   rej_q;
	logic [ARR_W-1:0]       arr_q;
	logic [SERVE_W-1:0]     serve_q;
	logic [31:0]            wait_q;
	logic [TIME_WIDTH-1:0]  end_q;
	logic [31:0]            total_q;
	logic [15:0]            count_q;
	logic                   out_valid_q;
	logic                   out_free;
	logic                   busy;
	logic [TIME_WIDTH-1:0]  diff;
	logic [31:0]            wait32;
	logic [TIME_WIDTH-1:0]  base;
	logic [TIME_WIDTH:0]    end_sum;
	logic [32:0]            total_sum;
	logic [31:0]            total_next;
	logic [15:0]            count_next;

	// Last window in use, with zero read as one window and large counts clamped.
	always_comb begin
		if (cfg.num_windows == 8'd0) begin
			last_idx = '0;
		end else if (32'(cfg.num_windows) > MAX_WINDOWS) begin
			last_idx = WIN_IDX_W'(MAX_WINDOWS - 1);
		end else begin
			last_idx = WIN_IDX_W'(cfg.num_windows - 8'd1);
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign out_valid = out_valid_q;
	assign rd_addr   = (state_q == S_IDLE) ? '0 : rd_idx_q + WIN_IDX_W'(1);

	// A window never written since reset or reload still ends at opening time.
	assign entry = rd_vld_q ? rd_data_q : TIME_WIDTH'(cfg.open_seconds);

	// Wait and new end time of the chosen window.
	always_comb begin
		busy   = best_val_q > TIME_WIDTH'(arr_q);
		diff   = best_val_q - TIME_WIDTH'(arr_q);
		wait32 = ((64'(diff) >> 32) != 64'd0) ? '1 : 32'(diff);
		base   = busy ? best_val_q : TIME_WIDTH'(arr_q);
		end_sum = {1'b0, base} + (TIME_WIDTH + 1)'(serve_q);
	end

	// Saturating running totals.
	always_comb begin
		total_sum  = {1'b0, total_q} + {1'b0, wait_q};
		total_next = total_sum[32] ? '1 : total_sum[31:0];
		count_next = (count_q == 16'hFFFF) ? count_q : count_q + 16'd1;
	end

	// End time store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (state_q == S_WRITE && out_free && !rej_q) begin
			mem[best_q] <= end_q;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Written marks, cleared at reset and whenever the opening time is reloaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WINDOWS; i++) begin
				vld_q[i] <= 1'b0;
			end
			rd_vld_q <= 1'b0;
		end else begin
			if (reload) begin
				for (int i = 0; i < MAX_WINDOWS; i++) begin
					vld_q[i] <= 1'b0;
				end
			end else if (state_q == S_WRITE && out_free && !rej_q) begin
				vld_q[best_q] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	// Sequencer: take an item, scan the windows, settle the wait, deliver; a rejected item goes straight to delivery.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			total_q     <= '0;
			count_q     <= '0;
		end else begin
			// The result register fills in the write state and empties on a transfer.
			if (state_q == S_WRITE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= q_item.rejected ? S_WRITE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_idx_q == last_idx) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (out_free) begin
						if (!rej_q) begin
							total_q <= total_next;
							count_q <= count_next;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers and the result register.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				rej_q    <= q_item.rejected;
				arr_q    <= q_item.arrive;
				serve_q  <= q_item.serve;
				rd_idx_q <= '0;
			end
			S_SCAN: begin
				if (rd_idx_q == '0 || entry < best_val_q) begin
					best_q     <= rd_idx_q;
					best_val_q <= entry;
				end
				rd_idx_q <= rd_idx_q + WIN_IDX_W'(1);
			end
			S_FINISH: begin
				wait_q <= busy ? wait32 : '0;
				end_q  <= end_sum[TIME_WIDTH] ? '1 : end_sum[TIME_WIDTH-1:0];
			end
			S_WRITE: begin
				if (out_free) begin
					accepted     <= !rej_q;
					window_index <= rej_q ? 7'd0 : 7'(best_q);
					wait_seconds <= rej_q ? 32'd0 : wait_q;
					total_wait_seconds <= rej_q ? total_q : total_next;
					accepted_count     <= rej_q ? count_q : count_next;
				end
			end
			default: begin
			end
		endcase
	end

	// The scan never runs past the last window in use.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (rd_idx_q <= last_idx))
		else $error("window scan beyond last window");

	// The chosen window lies within the windows in use.
	a_best_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && !rej_q) |-> (best_q <= last_idx))
		else $error("chosen window out of range");

	// Rejected customers report no window and no wait.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !accepted) |-> (window_index == 7'd0 && wait_seconds == 32'd0))
		else $error("rejected result carries window or wait");

	// Running totals never fall.
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && out_free) |=>
		(total_q >= $past(total_q) && count_q >= $past(count_q)))
		else $error("running totals decreased");

endmodule

// ----- sv/earliest_free_server_assigner.sv -----
// An accepted customer passes the front stage register, the queue and the idle, scan,
// finish and write states to the output register; one arriving after closing skips
// the scan and finish states. A new customer is taken only after the last has left the
// write state; the scan reads the end time store's single read port, one window a cycle.
// Reset clears totals and queue and restores the registers; every window then ends at
// the opening time at once through per-window written marks, with no clearing pass.
module earliest_free_server_assigner import efsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  arrive_hour,
	input  logic [5:0]  arrive_minute,
	input  logic [5:0]  arrive_second,
	input  logic [9:0]  service_minutes,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [6:0]  window_index,
	output logic [31:0] wait_seconds,
	output logic [31:0] total_wait_seconds,
	output logic [15:0] accepted_count
);

	cfg_t  cfg_q;
	logic  reload;
	logic  q_push;
	logic  q_pop;
	logic  q_full;
	logic  q_empty;
	item_t push_item;
	item_t pop_item;

	assign reload = cfg_we && (cfg_index == CFG_OPEN);

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_windows         <= RST_NUM_WINDOWS;
			cfg_q.open_seconds        <= RST_OPEN;
			cfg_q.close_seconds       <= RST_CLOSE;
			cfg_q.max_service_minutes <= RST_MAX_SERVICE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_WINDOWS: cfg_q.num_windows         <= cfg_data[7:0];
				CFG_OPEN:        cfg_q.open_seconds        <= cfg_data;
				CFG_CLOSE:       cfg_q.close_seconds       <= cfg_data;
				CFG_MAX_SERVICE: cfg_q.max_service_minutes <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	// Front end: conversion and classification.
	efsa_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.arrive_hour     (arrive_hour),
		.arrive_minute   (arrive_minute),
		.arrive_second   (arrive_second),
		.service_minutes (service_minutes),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_item          (push_item)
	);

	// Decoupling queue between front and back.
	efsa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	// Back end: window search, update and result register.
	efsa_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.reload             (reload),
		.q_item             (pop_item),
		.q_empty            (q_empty),
		.q_pop              (q_pop),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.accepted           (accepted),
		.window_index       (window_index),
		.wait_seconds       (wait_seconds),
		.total_wait_seconds (total_wait_seconds),
		.accepted_count     (accepted_count)
	);

endmodule
